// File: sv/svc_pkg.sv
// shared constants, mode codes and control types for the stokes visibility combiner
package svc_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int MODE_BITS       = 3;

    localparam logic [MODE_BITS-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_I     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_V     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_Q     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_U     = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_MERGE = 3'd5;

    typedef struct packed {
        logic use_harm;
        logic use_avg;
        logic wt_neg;
    } svc_ctl_t;

endpackage

// File: sv/svc_front.sv
// decode, multiply and sum stages ahead of the dividers
module svc_front
    import svc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [MODE_BITS-1:0]          mode,
    input  logic signed [SAMPLE_BITS-1:0] a_re,
    input  logic signed [SAMPLE_BITS-1:0] a_im,
    input  logic signed [SAMPLE_BITS-1:0] a_wt,
    input  logic signed [SAMPLE_BITS-1:0] b_re,
    input  logic signed [SAMPLE_BITS-1:0] b_im,
    input  logic signed [SAMPLE_BITS-1:0] b_wt,
    output logic                          f_valid,
    output svc_ctl_t                      f_ctl,
    output logic [SAMPLE_BITS-1:0]        f_re,
    output logic [SAMPLE_BITS-1:0]        f_im,
    output logic [SAMPLE_BITS-1:0]        f_wt,
    output logic                          f_neg_re,
    output logic                          f_neg_im,
    output logic [2*SAMPLE_BITS+1:0]      f_num_wt,
    output logic [2*SAMPLE_BITS+1:0]      f_num_re,
    output logic [2*SAMPLE_BITS+1:0]      f_num_im,
    output logic [SAMPLE_BITS:0]          f_den
);

    localparam int W  = SAMPLE_BITS;
    localparam int NW = 2 * SAMPLE_BITS + 2;

    // stage 1 combinational decode
    logic [W-1:0]   mag_a_next, mag_b_next;
    logic [W:0]     t_re, t_im, h_re, h_im, wsum;
    logic [W-1:0]   re_next, im_next, wt_next, wsat;
    svc_ctl_t       ctl_next;
    logic           zero_w, same_sign;

    // stage registers
    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    svc_ctl_t       s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [W-1:0]   s1_re_reg, s1_im_reg, s1_wt_reg;
    logic [W-1:0]   s2_re_reg, s2_im_reg, s2_wt_reg;
    logic [W-1:0]   s3_re_reg, s3_im_reg, s3_wt_reg;
    logic [W-1:0]   s1_mag_a_reg, s1_mag_b_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic [W:0]     s1_den_reg, s2_den_reg, s3_den_reg;

    logic [2*W-1:0]      pw_next, s2_pw_reg;
    logic signed [2*W:0] pxr_next, pxi_next, pyr_next, pyi_next;
    logic signed [2*W:0] s2_pxr_reg, s2_pxi_reg, s2_pyr_reg, s2_pyi_reg;

    logic [NW-1:0]  nre, nim, mre_next, mim_next;
    logic [NW-1:0]  s3_num_wt_reg, s3_num_re_reg, s3_num_im_reg;
    logic           s3_neg_re_reg, s3_neg_im_reg;

    assign mag_a_next = a_wt[W-1] ? (~a_wt + 1'b1) : a_wt;
    assign mag_b_next = b_wt[W-1] ? (~b_wt + 1'b1) : b_wt;

    assign zero_w    = (a_wt == '0) || (b_wt == '0);
    assign same_sign = (!a_wt[W-1] && !b_wt[W-1] && !zero_w) || (a_wt[W-1] && b_wt[W-1]);

    // saturated weight sum for the merge
    assign wsum = {a_wt[W-1], a_wt} + {b_wt[W-1], b_wt};
    assign wsat = (wsum[W] != wsum[W-1]) ?
                  (wsum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : wsum[W-1:0];

    always_comb
    begin
        case (mode)
            MODE_V:
            begin
                t_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
                t_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
            end
            MODE_U:
            begin
                t_re = {b_im[W-1], b_im} - {a_im[W-1], a_im};
                t_im = {a_re[W-1], a_re} - {b_re[W-1], b_re};
            end
            default:
            begin
                t_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
                t_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
            end
        endcase
    end

    // halve with truncation toward zero
    assign h_re = t_re + {{W{1'b0}}, t_re[W]};
    assign h_im = t_im + {{W{1'b0}}, t_im[W]};

    always_comb
    begin
        ctl_next = '0;
        re_next  = a_re;
        im_next  = a_im;
        wt_next  = a_wt;
        case (mode)
            MODE_I, MODE_V, MODE_Q, MODE_U:
            begin
                if (zero_w)
                begin
                    re_next = '0;
                    im_next = '0;
                    wt_next = '0;
                end
                else
                begin
                    re_next           = h_re[W:1];
                    im_next           = h_im[W:1];
                    ctl_next.use_harm = 1'b1;
                    ctl_next.wt_neg   = a_wt[W-1] || b_wt[W-1];
                end
            end
            MODE_MERGE:
            begin
                if (same_sign)
                begin
                    ctl_next.use_avg = 1'b1;
                    wt_next          = wsat;
                end
                else if (!a_wt[W-1] && a_wt != '0)
                begin
                    re_next = a_re;
                end
                else if (!b_wt[W-1] && b_wt != '0)
                begin
                    re_next = b_re;
                    im_next = b_im;
                    wt_next = b_wt;
                end
                else
                begin
                    re_next = '0;
                    im_next = '0;
                    wt_next = '0;
                end
            end
            default:
            begin
                re_next = a_re;
            end
        endcase
    end

    // stage 2 products
    assign pw_next  = (2*W)'(s1_mag_a_reg) * (2*W)'(s1_mag_b_reg);
    assign pxr_next = s1_ar_reg * $signed({1'b0, s1_mag_a_reg});
    assign pxi_next = s1_ai_reg * $signed({1'b0, s1_mag_a_reg});
    assign pyr_next = s1_br_reg * $signed({1'b0, s1_mag_b_reg});
    assign pyi_next = s1_bi_reg * $signed({1'b0, s1_mag_b_reg});

    // stage 3 sums and magnitudes
    assign nre      = {s2_pxr_reg[2*W], s2_pxr_reg} + {s2_pyr_reg[2*W], s2_pyr_reg};
    assign nim      = {s2_pxi_reg[2*W], s2_pxi_reg} + {s2_pyi_reg[2*W], s2_pyi_reg};
    assign mre_next = nre[NW-1] ? (~nre + 1'b1) : nre;
    assign mim_next = nim[NW-1] ? (~nim + 1'b1) : nim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg    <= ctl_next;
            s1_re_reg     <= re_next;
            s1_im_reg     <= im_next;
            s1_wt_reg     <= wt_next;
            s1_mag_a_reg  <= mag_a_next;
            s1_mag_b_reg  <= mag_b_next;
            s1_ar_reg     <= a_re;
            s1_ai_reg     <= a_im;
            s1_br_reg     <= b_re;
            s1_bi_reg     <= b_im;
            s1_den_reg    <= {1'b0, mag_a_next} + {1'b0, mag_b_next};

            s2_ctl_reg    <= s1_ctl_reg;
            s2_re_reg     <= s1_re_reg;
            s2_im_reg     <= s1_im_reg;
            s2_wt_reg     <= s1_wt_reg;
            s2_den_reg    <= s1_den_reg;
            s2_pw_reg     <= pw_next;
            s2_pxr_reg    <= pxr_next;
            s2_pxi_reg    <= pxi_next;
            s2_pyr_reg    <= pyr_next;
            s2_pyi_reg    <= pyi_next;

            s3_ctl_reg    <= s2_ctl_reg;
            s3_re_reg     <= s2_re_reg;
            s3_im_reg     <= s2_im_reg;
            s3_wt_reg     <= s2_wt_reg;
            s3_den_reg    <= s2_den_reg;
            s3_num_wt_reg <= {s2_pw_reg, 2'b00};
            s3_num_re_reg <= mre_next;
            s3_num_im_reg <= mim_next;
            s3_neg_re_reg <= nre[NW-1];
            s3_neg_im_reg <= nim[NW-1];
        end
    end

    assign f_valid  = s3_valid_reg;
    assign f_ctl    = s3_ctl_reg;
    assign f_re     = s3_re_reg;
    assign f_im     = s3_im_reg;
    assign f_wt     = s3_wt_reg;
    assign f_neg_re = s3_neg_re_reg;
    assign f_neg_im = s3_neg_im_reg;
    assign f_num_wt = s3_num_wt_reg;
    assign f_num_re = s3_num_re_reg;
    assign f_num_im = s3_num_im_reg;
    assign f_den    = s3_den_reg;

endmodule

// File: sv/svc_div.sv
// pipelined restoring divider, one quotient bit per stage
module svc_div
    import svc_pkg::*;
#(
    parameter int NW = 2 * SAMPLE_BITS_DEF + 2,
    parameter int DW = SAMPLE_BITS_DEF + 1,
    parameter int QW = SAMPLE_BITS_DEF + 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [NW-1:0] rem_prev, trial, rem_next;
        logic [DW-1:0] den_prev;
        logic [QW-1:0] quo_prev, quo_next;
        logic          fits;

        if (j == 0)
        begin : g_first
            assign rem_prev = num;
            assign den_prev = den;
            assign quo_prev = '0;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign den_prev = den_reg[j-1];
            assign quo_prev = quo_reg[j-1];
        end

        // divisor aligned to the current quotient bit
        assign trial    = NW'(den_prev) << (QW - 1 - j);
        assign fits     = rem_prev >= trial;
        assign rem_next = fits ? (rem_prev - trial) : rem_prev;
        assign quo_next = {quo_prev[QW-2:0], fits};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_prev;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// File: sv/stokes_visibility_combiner.sv
// top level of the stokes visibility combiner: front stages, dividers, output register
// pipeline: SAMPLE_BITS + 5 register stages: front, divider and output registers
// throughput: one transaction per cycle unless stalled, set by the bit-per-stage dividers
// the pipeline advances as a whole; it holds only while a result waits under out_stall
// reset: rst_n is asynchronous and active low; it clears valid bits and sets mode to pass a
// no clearing pass is needed, the block takes a transaction in the first cycle after reset
module stokes_visibility_combiner
    import svc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          mode_we,
    input  logic [MODE_BITS-1:0]          mode_wdata,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] a_re,
    input  logic signed [SAMPLE_BITS-1:0] a_im,
    input  logic signed [SAMPLE_BITS-1:0] a_wt,
    input  logic signed [SAMPLE_BITS-1:0] b_re,
    input  logic signed [SAMPLE_BITS-1:0] b_im,
    input  logic signed [SAMPLE_BITS-1:0] b_wt,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] res_re,
    output logic signed [SAMPLE_BITS-1:0] res_im,
    output logic signed [SAMPLE_BITS-1:0] res_wt
);

    localparam int W  = SAMPLE_BITS;
    localparam int NW = 2 * SAMPLE_BITS + 2;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int QW = SAMPLE_BITS + 1;
    // sideband delay matches the divider depth
    localparam int L  = QW;

    logic [MODE_BITS-1:0] mode_reg;
    logic                 en;

    // front stage outputs
    logic          f_valid, f_neg_re, f_neg_im;
    svc_ctl_t      f_ctl;
    logic [W-1:0]  f_re, f_im, f_wt;
    logic [NW-1:0] f_num_wt, f_num_re, f_num_im;
    logic [DW-1:0] f_den;

    // divider quotients
    logic [QW-1:0] q_wt, q_re, q_im;

    // sideband delay line carried alongside the dividers
    logic          sb_valid_reg [L];
    svc_ctl_t      sb_ctl_reg   [L];
    logic [W-1:0]  sb_re_reg    [L];
    logic [W-1:0]  sb_im_reg    [L];
    logic [W-1:0]  sb_wt_reg    [L];
    logic          sb_neg_re_reg[L];
    logic          sb_neg_im_reg[L];

    // output register
    logic          out_valid_reg;
    logic [W-1:0]  res_re_reg, res_im_reg, res_wt_reg;
    logic [W-1:0]  res_re_next, res_im_next, res_wt_next;
    logic [W-1:0]  harm_wt, avg_re, avg_im;
    svc_ctl_t      end_ctl;

    // the whole pipeline moves unless a finished result is held by the sink
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PASS;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_wdata;
        end
    end

    svc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .mode     (mode_reg),
        .a_re     (a_re),
        .a_im     (a_im),
        .a_wt     (a_wt),
        .b_re     (b_re),
        .b_im     (b_im),
        .b_wt     (b_wt),
        .f_valid  (f_valid),
        .f_ctl    (f_ctl),
        .f_re     (f_re),
        .f_im     (f_im),
        .f_wt     (f_wt),
        .f_neg_re (f_neg_re),
        .f_neg_im (f_neg_im),
        .f_num_wt (f_num_wt),
        .f_num_re (f_num_re),
        .f_num_im (f_num_im),
        .f_den    (f_den)
    );

    // harmonic weight: 4|a||b| / (|a|+|b|)
    svc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_wt (
        .clk (clk), .en (en), .num (f_num_wt), .den (f_den), .quo (q_wt)
    );

    // weighted average of the real parts
    svc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_re (
        .clk (clk), .en (en), .num (f_num_re), .den (f_den), .quo (q_re)
    );

    // weighted average of the imaginary parts
    svc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_im (
        .clk (clk), .en (en), .num (f_num_im), .den (f_den), .quo (q_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                sb_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            sb_valid_reg[0] <= f_valid;
            for (int k = 1; k < L; k++)
            begin
                sb_valid_reg[k] <= sb_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_ctl_reg[0]    <= f_ctl;
            sb_re_reg[0]     <= f_re;
            sb_im_reg[0]     <= f_im;
            sb_wt_reg[0]     <= f_wt;
            sb_neg_re_reg[0] <= f_neg_re;
            sb_neg_im_reg[0] <= f_neg_im;
            for (int k = 1; k < L; k++)
            begin
                sb_ctl_reg[k]    <= sb_ctl_reg[k-1];
                sb_re_reg[k]     <= sb_re_reg[k-1];
                sb_im_reg[k]     <= sb_im_reg[k-1];
                sb_wt_reg[k]     <= sb_wt_reg[k-1];
                sb_neg_re_reg[k] <= sb_neg_re_reg[k-1];
                sb_neg_im_reg[k] <= sb_neg_im_reg[k-1];
            end
        end
    end

    assign end_ctl = sb_ctl_reg[L-1];

    // saturate the harmonic weight and apply the flag sign
    always_comb
    begin
        if (end_ctl.wt_neg)
        begin
            if (q_wt > {2'b01, {(W-1){1'b0}}})
            begin
                harm_wt = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                harm_wt = ~q_wt[W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (q_wt > {2'b00, {(W-1){1'b1}}})
            begin
                harm_wt = {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                harm_wt = q_wt[W-1:0];
            end
        end
    end

    // quotient of a magnitude, sign restored (truncation toward zero)
    assign avg_re = sb_neg_re_reg[L-1] ? (~q_re[W-1:0] + 1'b1) : q_re[W-1:0];
    assign avg_im = sb_neg_im_reg[L-1] ? (~q_im[W-1:0] + 1'b1) : q_im[W-1:0];

    always_comb
    begin
        res_re_next = sb_re_reg[L-1];
        res_im_next = sb_im_reg[L-1];
        res_wt_next = sb_wt_reg[L-1];
        if (end_ctl.use_harm)
        begin
            res_wt_next = harm_wt;
        end
        if (end_ctl.use_avg)
        begin
            res_re_next = avg_re;
            res_im_next = avg_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sb_valid_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            res_wt_reg <= res_wt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign res_wt    = res_wt_reg;

endmodule

// File: sv/svc_checker.sv
// port-level checker for the stokes visibility combiner and its bind
module svc_checker
    import svc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] res_re,
    input logic signed [SAMPLE_BITS-1:0] res_im,
    input logic signed [SAMPLE_BITS-1:0] res_wt
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(res_re) && $stable(res_im) && $stable(res_wt))
        else $error("result payload changed while stalled");

    // backpressure reaches the input whenever a result is held
    a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output held");

    // an empty output register never stalls the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

endmodule

bind stokes_visibility_combiner svc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_svc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .res_wt    (res_wt)
);

// File: tb/tb_stokes_visibility_combiner.sv
// self-checking testbench for the stokes visibility combiner
module tb_stokes_visibility_combiner;
    import svc_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = W + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [W-1:0] samp_t;

    typedef struct {
        samp_t re;
        samp_t im;
        samp_t wt;
    } vis_t;

    // models the combiner and holds the visibilities it still expects to see
    class combined_vis_board;
        logic [MODE_BITS-1:0] mode;
        vis_t pending[$];
        int errors;
        int checked;

        function new();
            mode = MODE_PASS;
            errors = 0;
            checked = 0;
        endfunction

        function longint sat(longint x);
            longint smax;
            smax = (64'sd1 <<< (W - 1)) - 1;
            if (x > smax) return smax;
            if (x < -smax - 1) return -smax - 1;
            return x;
        endfunction

        function longint harm_wt(longint aw, longint bw);
            logic [127:0] prod;
            logic [127:0] q;
            longint ma;
            longint mb;
            ma = aw < 0 ? -aw : aw;
            mb = bw < 0 ? -bw : bw;
            prod = 128'(ma) * 128'(mb) * 4;
            q = prod / 128'(ma + mb);
            if (aw < 0 || bw < 0)
                return sat(-longint'(q));
            return sat(longint'(q));
        endfunction

        // weighted mean, truncated toward zero
        function longint wmean(longint x, longint wx, longint y, longint wy);
            logic signed [127:0] num;
            logic [127:0] mg;
            logic [127:0] q;
            num = 128'(signed'(x)) * 128'(signed'(wx)) + 128'(signed'(y)) * 128'(signed'(wy));
            mg = num < 0 ? -num : num;
            q = mg / 128'(wx + wy);
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_input(vis_t a, vis_t b);
            longint ar, ai, aw, br, bi, bw, rr, ri, rw, ma, mb;
            vis_t e;
            ar = a.re; ai = a.im; aw = a.wt;
            br = b.re; bi = b.im; bw = b.wt;
            rr = ar; ri = ai; rw = aw;
            case (mode)
                MODE_I, MODE_V, MODE_Q, MODE_U:
                begin
                    if (aw == 0 || bw == 0)
                    begin
                        rr = 0; ri = 0; rw = 0;
                    end
                    else
                    begin
                        if (mode == MODE_V)
                        begin
                            rr = (ar - br) / 2; ri = (ai - bi) / 2;
                        end
                        else if (mode == MODE_U)
                        begin
                            rr = (bi - ai) / 2; ri = (ar - br) / 2;
                        end
                        else
                        begin
                            rr = (ar + br) / 2; ri = (ai + bi) / 2;
                        end
                        rw = harm_wt(aw, bw);
                    end
                end
                MODE_MERGE:
                begin
                    ma = aw < 0 ? -aw : aw;
                    mb = bw < 0 ? -bw : bw;
                    if ((aw > 0 && bw > 0) || (aw < 0 && bw < 0))
                    begin
                        rr = wmean(ar, ma, br, mb);
                        ri = wmean(ai, ma, bi, mb);
                        rw = sat(aw + bw);
                    end
                    else if (aw > 0)
                    begin
                        rr = ar; ri = ai; rw = aw;
                    end
                    else if (bw > 0)
                    begin
                        rr = br; ri = bi; rw = bw;
                    end
                    else
                    begin
                        rr = 0; ri = 0; rw = 0;
                    end
                end
                default:
                begin
                end
            endcase
            e.re = samp_t'(rr);
            e.im = samp_t'(ri);
            e.wt = samp_t'(rw);
            pending.push_back(e);
        endfunction

        task report(string what, samp_t got, samp_t want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(vis_t got);
            vis_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("mismatch: unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.re !== e.re) report("res_re", got.re, e.re);
            if (got.im !== e.im) report("res_im", got.im, e.im);
            if (got.wt !== e.wt) report("res_wt", got.wt, e.wt);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic mode_we;
    logic [MODE_BITS-1:0] mode_wdata;
    logic in_valid;
    logic in_stall;
    samp_t a_re, a_im, a_wt, b_re, b_im, b_wt;
    logic out_valid;
    logic out_stall;
    samp_t res_re, res_im, res_wt;

    combined_vis_board board;
    longint cycles;
    int sent;

    stokes_visibility_combiner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode_we   (mode_we),
        .mode_wdata(mode_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_re      (a_re),
        .a_im      (a_im),
        .a_wt      (a_wt),
        .b_re      (b_re),
        .b_im      (b_im),
        .b_wt      (b_wt),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .res_wt    (res_wt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_stokes_visibility_combiner: errors");
            $finish;
        end
    end

    // result side: random stall per transaction, check at the rising edge
    initial
    begin
        int gap;
        vis_t got;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 4) == 0) gap = 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got.re = res_re; got.im = res_im; got.wt = res_wt;
            board.check_result(got);
            @(negedge clk);
        end
    end

    // random weight biased toward the special cases
    function automatic samp_t rand_wt();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return samp_t'(-$urandom_range(1, 1 << 20));
            2: return {1'b1, 31'd0};
            3: return {1'b0, {31{1'b1}}};
            4: return samp_t'($urandom);
            5: return samp_t'(-$urandom_range(1, 1 << 18));
            default: return samp_t'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    function automatic samp_t rand_val();
        case ($urandom_range(0, 5))
            0: return samp_t'($urandom);
            1: return {1'b1, 31'd0};
            2: return {1'b0, {31{1'b1}}};
            default: return samp_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // one input transaction: random gap first, then hold until accepted
    task automatic send_vis(samp_t ar, samp_t ai, samp_t aw, samp_t br, samp_t bi, samp_t bw,
                            bit no_gap);
        int gap;
        vis_t a, b;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a_re <= ar; a_im <= ai; a_wt <= aw;
        b_re <= br; b_im <= bi; b_wt <= bw;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        a.re = ar; a.im = ai; a.wt = aw;
        b.re = br; b.im = bi; b.wt = bw;
        board.note_input(a, b);
        sent++;
    endtask

    // drop valid after the last transaction of a burst
    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // write mode only with the pipeline empty
    task automatic set_mode(logic [MODE_BITS-1:0] m);
        release_input();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
        mode_we <= 1'b1;
        mode_wdata <= m;
        @(negedge clk);
        mode_we <= 1'b0;
        board.mode = m;
    endtask

    task automatic directed_set();
        samp_t mx, mn;
        mx = {1'b0, {31{1'b1}}};
        mn = {1'b1, 31'd0};
        send_vis(mx, mn, mx, mn, mx, mx, 1);
        send_vis(mn, mx, mn, mx, mn, mn, 1);
        send_vis(100, -7, 0, 5, 3, 65536, 0);
        send_vis(-3, 9, 65536, 7, -1, 0, 0);
        send_vis(65536, -65536, -65536, 3, 1, 131072, 0);
        send_vis(-1, 1, 65536, 1, -1, -65536, 0);
        send_vis(-5, 5, -100, 7, -9, -300, 1);
        send_vis(1, -1, 0, 2, 2, 0, 0);
        send_vis(12345, -999, 1, 777, 4, 1, 0);
        send_vis(mx, mx, mx, mx, mx, mx, 0);
    endtask

    initial
    begin
        logic [MODE_BITS-1:0] m;
        board = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        mode_we = 1'b0;
        mode_wdata = MODE_PASS;
        in_valid = 1'b0;
        {a_re, a_im, a_wt, b_re, b_im, b_wt} = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass through every mode, including the unused codes
        for (int k = 0; k < 8; k++)
        begin
            m = k[MODE_BITS-1:0];
            if (k > 0) set_mode(m);
            directed_set();
        end

        // random part: random mode per phase, extremes included
        for (int p = 0; p < 12; p++)
        begin
            if (p == 0) m = MODE_MERGE;
            else if (p == 1) m = 3'd7;
            else m = $urandom_range(0, 7);
            set_mode(m);
            for (int k = 0; k < 32; k++)
            begin
                send_vis(rand_val(), rand_val(), rand_wt(), rand_val(), rand_val(), rand_wt(),
                         (p % 3) == 2);
                // sender holds off until the pipeline drains
                if (p == 4 && k == 10)
                begin
                    release_input();
                    while (board.pending.size() != 0) @(negedge clk);
                end
            end
        end
        release_input();

        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d visibility pairs through all eight mode codes, checked %0d results",
                 sent, board.checked);
        if (board.errors == 0)
            $display("tb_stokes_visibility_combiner: clean");
        else
            $display("tb_stokes_visibility_combiner: errors");
        $finish;
    end

endmodule
